// File: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, op codes, character codes and reset values for the
// text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int COLR_W = 4;
	localparam int ADDR_W = 11;
	localparam int DATA_W = 16;
	localparam int LOC_W  = 11;
	localparam int ATTR_W = 8;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

	localparam int TAB_STEP = 8;

	localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h0F;
	localparam logic [DATA_W-1:0] RESET_CELL     = 16'h0F20;

endpackage

// File: hw/rtl/text_console_char_writer.sv
// ----------------------------------------------------------------------------
// text_console_char_writer
// Text console with a COLUMNS x ROWS cell memory and a cursor; puts
// characters, clears the screen, scrolls and reads back cells.
// ----------------------------------------------------------------------------
// steps: put ends in EXEC; read waits in RDWAIT; clear runs a FILL pass; a put
//   that scrolls runs SCROLL then FILL (one memory port, one cell a cycle)
// throughput: one item at a time, busy high from accept until done
// reset: cursor homed, blank attribute 0x0f, then a clearing pass writes 0x0f20
//   to every cell, busy high
// done pulses for one cycle with the result; the receiver cannot stall
module text_console_char_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [tcw_pkg::OP_W-1:0]    op,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::COLR_W-1:0]  background,
	input  logic [tcw_pkg::COLR_W-1:0]  foreground,
	input  logic [tcw_pkg::ADDR_W-1:0]  cell_address,
	input  logic                        blank_attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]  blank_attribute,
	output logic                        done,
	output logic [tcw_pkg::DATA_W-1:0]  cell_data,
	output logic [tcw_pkg::LOC_W-1:0]   cursor_pos
);
	import tcw_pkg::*;

	localparam int CELLS     = COLUMNS * ROWS;
	localparam int AW        = $clog2(CELLS);
	localparam int CNT_W     = $clog2(CELLS + 1);
	localparam int CW        = $clog2(COLUMNS);
	localparam int RW        = $clog2(ROWS);
	localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_RDWAIT = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_FILL   = 6'b100000
	} state_t;

	state_t state_q;
	logic   clear_q;

	logic [ATTR_W-1:0] blank_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DATA_W-1:0] cell_data_q;

	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [ATTR_W-1:0] attr_q;
	logic [AW-1:0]     addr_q;
	logic              rd_ok_q;

	logic              copy_s1;
	logic [AW-1:0]     addr_s1;

	logic [DATA_W-1:0] mem [CELLS];
	logic [DATA_W-1:0] rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              rd_en;
	logic [AW-1:0]     mem_raddr;

	logic              is_bs;
	logic              is_tab;
	logic              is_cr;
	logic              is_lf;
	logic              is_prt;
	logic [CW:0]       tab_col;
	logic              newline;
	logic              scroll_go;
	logic [CW-1:0]     col_n;
	logic [RW-1:0]     row_n;
	logic [AW-1:0]     pos_n;
	logic              accept;
	logic              cnt_end;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign cnt_end = (cnt_q == CNT_W'(CELLS - 1));

	// cursor update for a put
	always_comb begin
		is_bs   = (ch_q == CH_BS) && (col_q != '0);
		is_tab  = (ch_q == CH_TAB);
		is_cr   = (ch_q == CH_CR);
		is_lf   = (ch_q == CH_LF);
		is_prt  = (ch_q >= CH_SPACE) && (ch_q <= CH_LAST);
		tab_col = ({1'b0, col_q} + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
		newline   = 1'b0;
		scroll_go = 1'b0;
		col_n     = col_q;
		row_n     = row_q;
		pos_n     = pos_q;
		if (is_bs) begin
			col_n = col_q - 1'b1;
			pos_n = pos_q - 1'b1;
		end else if (is_tab) begin
			if (tab_col >= (CW+1)'(COLUMNS)) begin
				newline = 1'b1;
			end else begin
				col_n = tab_col[CW-1:0];
				pos_n = pos_q + AW'(tab_col - {1'b0, col_q});
			end
		end else if (is_cr) begin
			col_n = '0;
			pos_n = pos_q - AW'(col_q);
		end else if (is_lf) begin
			newline = 1'b1;
		end else if (is_prt) begin
			if (({1'b0, col_q} + 1'b1) == (CW+1)'(COLUMNS)) begin
				newline = 1'b1;
			end else begin
				col_n = col_q + 1'b1;
				pos_n = pos_q + 1'b1;
			end
		end
		if (newline) begin
			col_n = '0;
			if (row_q == RW'(ROWS - 1)) begin
				scroll_go = 1'b1;
				pos_n     = AW'(LAST_BASE);
			end else begin
				row_n = row_q + 1'b1;
				pos_n = pos_q - AW'(col_q) + AW'(COLUMNS);
			end
		end
	end

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = RESET_CELL;
		rd_en     = 1'b0;
		mem_raddr = cnt_q[AW-1:0];
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
			end
			ST_EXEC: begin
				if (op_q == OP_PUT && is_bs) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q - 1'b1;
					mem_wdata = {attr_q, CH_SPACE};
				end else if (op_q == OP_PUT && is_prt) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = {attr_q, ch_q};
				end
				if (op_q == OP_READ) begin
					rd_en     = rd_ok_q;
					mem_raddr = addr_q;
				end
			end
			ST_SCROLL: begin
				rd_en     = (cnt_q != CNT_W'(CELLS));
				mem_we    = copy_s1;
				mem_waddr = addr_s1;
				mem_wdata = rd_q;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = {blank_q, CH_SPACE};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// latched item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			ch_q    <= char_code;
			attr_q  <= {background, foreground};
			addr_q  <= AW'(cell_address);
			rd_ok_q <= (32'(cell_address) < 32'(CELLS));
		end
		addr_s1 <= AW'(cnt_q - CNT_W'(COLUMNS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_q <= BLANK_ATTR_RST;
		end else if (blank_attribute_we) begin
			blank_q <= blank_attribute;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clear_q     <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			cell_data_q <= '0;
			copy_s1     <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			copy_s1 <= 1'b0;
			case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cell_data_q <= '0;
					case (op_q)
						OP_PUT: begin
							col_q <= col_n;
							row_q <= row_n;
							pos_q <= pos_n;
							if (scroll_go) begin
								cnt_q   <= CNT_W'(COLUMNS);
								state_q <= ST_SCROLL;
							end else begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						OP_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							pos_q   <= '0;
							cnt_q   <= '0;
							clear_q <= 1'b1;
							state_q <= ST_FILL;
						end
						OP_READ: begin
							if (rd_ok_q) begin
								state_q <= ST_RDWAIT;
							end else begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_RDWAIT: begin
					cell_data_q <= rd_q;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_SCROLL: begin
					if (cnt_q != CNT_W'(CELLS)) begin
						copy_s1 <= 1'b1;
						cnt_q   <= cnt_q + 1'b1;
					end else begin
						cnt_q   <= CNT_W'(CELLS - COLUMNS);
						clear_q <= 1'b0;
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) begin
						cell_data_q <= '0;
						done_q      <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign cell_data  = cell_data_q;
	assign cursor_pos = LOC_W'(pos_q);

	// clear_q marks a fill pass that started from a clear item
	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && clear_q) |-> (pos_q == '0))
		else $error("clear pass with cursor not homed");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("item accepted but block not busy");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pos_q) < 32'(CELLS))
		else $error("cursor beyond last cell");

	a_idle_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !mem_we)
		else $error("cell write while idle");

	a_pos_match: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (32'(pos_q) == 32'(row_q) * COLUMNS + 32'(col_q)))
		else $error("cursor position out of step with row and column");

endmodule

// File: tb/text_console_checker.sv
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the item, result and blank attribute ports of the text console,
// keeps its own copy of the cell store and cursor, predicts the result of
// every accepted item and compares each result field against it.
// ----------------------------------------------------------------------------
module text_console_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [tcw_pkg::OP_W-1:0]    op,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::COLR_W-1:0]  background,
	input  logic [tcw_pkg::COLR_W-1:0]  foreground,
	input  logic [tcw_pkg::ADDR_W-1:0]  cell_address,
	input  logic                        blank_attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]  blank_attribute,
	input  logic                        done,
	input  logic [tcw_pkg::DATA_W-1:0]  cell_data,
	input  logic [tcw_pkg::LOC_W-1:0]   cursor_pos,
	output int                          fail_count,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	typedef struct {
		logic [DATA_W-1:0] data;
		logic [LOC_W-1:0]  loc;
	} console_result_t;

	logic [DATA_W-1:0] screen [CELLS];
	int unsigned       cur_col;
	int unsigned       cur_row;
	logic [ATTR_W-1:0] fill_attr;
	console_result_t   pending_results [$];
	console_result_t   want;
	console_result_t   got;

	task automatic put_character(input logic [CHAR_W-1:0] ch, input logic [COLR_W-1:0] bg,
		input logic [COLR_W-1:0] fg);
		logic [ATTR_W-1:0] attr;
		int unsigned       pos;
		attr = {bg, fg};
		pos  = cur_row * COLUMNS + cur_col;
		if (ch == CH_BS && cur_col != 0) begin
			screen[pos - 1] = {attr, CH_SPACE};
			cur_col--;
		end else if (ch == CH_TAB) begin
			cur_col = (cur_col + TAB_STEP) / TAB_STEP * TAB_STEP;
		end else if (ch == CH_CR) begin
			cur_col = 0;
		end else if (ch == CH_LF) begin
			cur_col = 0;
			cur_row++;
		end else if (ch >= CH_SPACE && ch <= CH_LAST) begin
			screen[pos] = {attr, ch};
			cur_col++;
		end
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		// scroll up one row, blank the bottom row
		if (cur_row >= ROWS) begin
			for (int i = 0; i < CELLS - COLUMNS; i++)
				screen[i] = screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = {fill_attr, CH_SPACE};
			cur_row = ROWS - 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = RESET_CELL;
			cur_col     = 0;
			cur_row     = 0;
			fill_attr   = BLANK_ATTR_RST;
			fail_count  = 0;
			outstanding = 0;
			pending_results.delete();
		end else begin
			if (done) begin
				got.data = cell_data;
				got.loc  = cursor_pos;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected item result, cell_data %h cursor_pos %0d",
						$time, got.data, got.loc);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.data !== want.data) begin
						$display("%0t: cell_data mismatch, expected %h actual %h",
							$time, want.data, got.data);
						fail_count++;
					end
					if (got.loc !== want.loc) begin
						$display("%0t: cursor_pos mismatch, expected %0d actual %0d",
							$time, want.loc, got.loc);
						fail_count++;
					end
				end
			end
			if (blank_attribute_we)
				fill_attr = blank_attribute;
			if (start && !busy) begin
				want.data = '0;
				case (op)
					OP_PUT: begin
						put_character(char_code, background, foreground);
					end
					OP_CLEAR: begin
						for (int i = 0; i < CELLS; i++)
							screen[i] = {fill_attr, CH_SPACE};
						cur_col = 0;
						cur_row = 0;
					end
					OP_READ: begin
						if (cell_address < CELLS)
							want.data = screen[cell_address];
					end
					default: begin
					end
				endcase
				want.loc = LOC_W'(cur_row * COLUMNS + cur_col);
				pending_results.push_back(want);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the text console with a directed set of items and then random
// phases of puts, controls, clears and reads under varying sender idling
// and blank attribute settings; the checker beside the block judges results.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [OP_W-1:0]   op = '0;
	logic [CHAR_W-1:0] char_code = '0;
	logic [COLR_W-1:0] background = '0;
	logic [COLR_W-1:0] foreground = '0;
	logic [ADDR_W-1:0] cell_address = '0;
	logic              blank_attribute_we = 1'b0;
	logic [ATTR_W-1:0] blank_attribute = '0;
	logic              busy;
	logic              done;
	logic [DATA_W-1:0] cell_data;
	logic [LOC_W-1:0]  cursor_pos;
	logic [LOC_W-1:0]  last_loc = '0;
	int                fail_count;
	int                outstanding;
	int                idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_console_char_writer DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.op                (op),
		.char_code         (char_code),
		.background        (background),
		.foreground        (foreground),
		.cell_address      (cell_address),
		.blank_attribute_we(blank_attribute_we),
		.blank_attribute   (blank_attribute),
		.done              (done),
		.cell_data         (cell_data),
		.cursor_pos        (cursor_pos)
	);

	text_console_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.op                (op),
		.char_code         (char_code),
		.background        (background),
		.foreground        (foreground),
		.cell_address      (cell_address),
		.blank_attribute_we(blank_attribute_we),
		.blank_attribute   (blank_attribute),
		.done              (done),
		.cell_data         (cell_data),
		.cursor_pos        (cursor_pos),
		.fail_count        (fail_count),
		.outstanding       (outstanding)
	);

	// cursor seen on the last result, used to aim reads at written cells
	always @(posedge clk)
		if (done)
			last_loc <= cursor_pos;

	// called at a rising edge; returns at the edge that accepts the item
	task automatic issue_item(input logic [OP_W-1:0] o, input logic [CHAR_W-1:0] ch,
		input logic [COLR_W-1:0] bg, input logic [COLR_W-1:0] fg,
		input logic [ADDR_W-1:0] addr);
		bit ready;
		start        <= 1'b1;
		op           <= o;
		char_code    <= ch;
		background   <= bg;
		foreground   <= fg;
		cell_address <= addr;
		do begin
			@(negedge clk);
			ready = !busy;
			@(posedge clk);
		end while (!ready);
	endtask

	task automatic sender_gap();
		if (int'($urandom_range(0, 99)) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic write_blank_attribute(input logic [ATTR_W-1:0] value);
		start <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0 || busy);
		@(posedge clk);
		blank_attribute_we <= 1'b1;
		blank_attribute    <= value;
		@(posedge clk);
		blank_attribute_we <= 1'b0;
	endtask

	task automatic send_random_item();
		int unsigned       sel;
		int unsigned       kind;
		int                near;
		logic [OP_W-1:0]   o;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
		sel  = $urandom_range(0, 999);
		kind = $urandom_range(0, 99);
		ch   = CHAR_W'($urandom_range(0, 255));
		addr = ADDR_W'($urandom_range(0, 2047));
		if (sel < 15) begin
			o = OP_CLEAR;
		end else if (sel < 35) begin
			o = OP_UNUSED;
		end else if (sel < 280) begin
			o = OP_READ;
			if (kind < 50) begin
				near = int'(last_loc) - int'($urandom_range(0, 90));
				addr = ADDR_W'((near < 0) ? 0 : near);
			end else if (kind < 95) begin
				addr = ADDR_W'($urandom_range(0, 1999));
			end else begin
				addr = ADDR_W'($urandom_range(2000, 2047));
			end
		end else begin
			o = OP_PUT;
			if (kind < 62)
				ch = CHAR_W'($urandom_range(CH_SPACE, CH_LAST));
			else if (kind < 70)
				ch = CH_BS;
			else if (kind < 76)
				ch = CH_TAB;
			else if (kind < 80)
				ch = CH_CR;
			else if (kind < 85)
				ch = CH_LF;
			else if (kind < 93)
				ch = CHAR_W'($urandom_range(0, 8'h1F));
			else
				ch = CHAR_W'($urandom_range(8'h80, 8'hFF));
		end
		issue_item(o, ch, COLR_W'($urandom_range(0, 15)), COLR_W'($urandom_range(0, 15)),
			addr);
	endtask

	initial begin
		#100_000_000;
		$display("text_console_char_writer verification failed");
		$finish;
	end

	initial begin
		idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, range edges, every control and op
		issue_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
		issue_item(OP_READ, 8'hFF, 4'hF, 4'hF, 11'd1999);
		issue_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2000);
		issue_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2047);
		issue_item(OP_PUT, 8'h41, 4'hF, 4'h0, 11'd0);
		issue_item(OP_PUT, CH_SPACE, 4'h0, 4'hF, 11'h7FF);
		issue_item(OP_PUT, CH_LAST, 4'hA, 4'h5, 11'd0);
		issue_item(OP_PUT, CH_BS, 4'h3, 4'hC, 11'd0);
		issue_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd2);
		issue_item(OP_PUT, CH_TAB, 4'h0, 4'h0, 11'd0);
		issue_item(OP_PUT, CH_CR, 4'h0, 4'h0, 11'd0);
		issue_item(OP_PUT, CH_BS, 4'h5, 4'h6, 11'd0);
		issue_item(OP_PUT, 8'h00, 4'h0, 4'h0, 11'd0);
		issue_item(OP_PUT, 8'h1F, 4'h0, 4'h0, 11'd0);
		issue_item(OP_PUT, 8'h80, 4'h0, 4'h0, 11'd0);
		issue_item(OP_PUT, 8'hFF, 4'h0, 4'h0, 11'd0);
		issue_item(OP_UNUSED, 8'h41, 4'hF, 4'hF, 11'd0);
		issue_item(OP_PUT, CH_LF, 4'h0, 4'h0, 11'd0);
		issue_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);
		issue_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd1);
		issue_item(OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0);
		issue_item(OP_READ, 8'h00, 4'h0, 4'h0, 11'd0);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_blank_attribute(8'hFF);
				1: write_blank_attribute(8'h00);
				default: write_blank_attribute(ATTR_W'($urandom_range(0, 255)));
			endcase
			idle_pct = (phase == 1) ? 75 : (phase == 3) ? 29 : 0;
			issue_item(OP_CLEAR, 8'h00, 4'h0, 4'h0, 11'd0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sender_gap();
				send_random_item();
			end
		end

		start <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("text_console_char_writer verification clean");
		else
			$display("text_console_char_writer verification failed");
		$finish;
	end

endmodule
